[design/string_to_integer_parser_core_macros.svh]
// assertion macros for the string to integer parser
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef STRING_TO_INTEGER_PARSER_CORE_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define STRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("strp: same-cycle check failed");

// next-cycle implication, disabled during reset
`define STRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("strp: next-cycle check failed");

`endif

[design/strp_pkg.sv]
// shared types and constants for the string to integer parser
// no dependencies
`timescale 1ns / 1ps

package strp_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BASE_W  = 6;

  // parse phase codes
  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_FIRST  = 3'd2;
  localparam logic [2:0] PH_ZX     = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  // radix limits and fixed radices
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  // parse control state passed between the step logic and the state registers
  typedef struct packed {
    logic [2:0]        phase;
    logic              minus;
    logic              lone_zero;
    logic [BASE_W-1:0] base;
  } strp_ctrl_t;

endpackage

[design/strp_step.sv]
// next-state and result logic for one character of the parser
// depends on strp_pkg
`timescale 1ns / 1ps

module strp_step import strp_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  strp_ctrl_t               ctrl_i,
  input  logic [VALUE_W-1:0]       acc_i,
  input  logic [OFFSET_BITS-1:0]   cnt_i,
  input  logic [BASE_W-1:0]        number_base_i,
  input  logic [7:0]               char_i,
  input  logic                     first_i,
  output strp_ctrl_t               ctrl_o,
  output logic [VALUE_W-1:0]       acc_o,
  output logic [OFFSET_BITS-1:0]   cnt_o,
  output logic                     res_valid_o,
  output logic [VALUE_W-1:0]       res_value_o,
  output logic [OFFSET_BITS-1:0]   res_offset_o
);

  logic                   dig_ok;
  logic [BASE_W-1:0]      dig_val;
  logic [OFFSET_BITS-1:0] cnt_base;
  logic [OFFSET_BITS:0]   sum1;
  logic [OFFSET_BITS:0]   sum2;
  logic [OFFSET_BITS-1:0] cnt_inc1;
  logic [OFFSET_BITS-1:0] cnt_inc2;
  logic [VALUE_W-1:0]     acc_mac;

  // character to digit value
  always_comb begin
    dig_ok  = 1'b1;
    dig_val = '0;
    if (char_i >= CH_ZERO && char_i <= CH_NINE) begin
      dig_val = BASE_W'(char_i - CH_ZERO);
    end else if (char_i >= CH_LA && char_i <= CH_LZ) begin
      dig_val = BASE_W'(char_i - CH_LA + 8'd10);
    end else if (char_i >= CH_UA && char_i <= CH_UZ) begin
      dig_val = BASE_W'(char_i - CH_UA + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  // saturating character count, cleared at a string start
  assign cnt_base = first_i ? '0 : cnt_i;
  assign sum1     = {1'b0, cnt_base} + (OFFSET_BITS+1)'(1);
  assign sum2     = {1'b0, cnt_base} + (OFFSET_BITS+1)'(2);
  assign cnt_inc1 = sum1[OFFSET_BITS] ? '1 : sum1[OFFSET_BITS-1:0];
  assign cnt_inc2 = sum2[OFFSET_BITS] ? '1 : sum2[OFFSET_BITS-1:0];

  // accumulator multiply-add, wraps modulo 2^64
  assign acc_mac = acc_i * {{(VALUE_W-BASE_W){1'b0}}, ctrl_i.base}
                 + {{(VALUE_W-BASE_W){1'b0}}, dig_val};

  // parse state machine
  always_comb begin
    logic take_first;
    ctrl_o       = ctrl_i;
    acc_o        = acc_i;
    cnt_o        = cnt_i;
    res_valid_o  = 1'b0;
    res_value_o  = '0;
    res_offset_o = '0;
    take_first   = 1'b0;

    // new string: clear and sample the radix
    if (first_i) begin
      ctrl_o.phase     = PH_LEAD;
      ctrl_o.minus     = 1'b0;
      ctrl_o.lone_zero = 1'b0;
      ctrl_o.base      = number_base_i;
      acc_o            = '0;
      cnt_o            = '0;
      if (number_base_i == BASE_ONE || number_base_i > BASE_MAX) begin
        res_valid_o  = 1'b1;
        ctrl_o.phase = PH_DONE;
      end
    end

    if (!res_valid_o) begin
      unique case (ctrl_o.phase)
        PH_LEAD: begin
          if (char_i == CH_SPACE || char_i == CH_TAB) begin
            cnt_o = cnt_inc1;
          end else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
            ctrl_o.minus = (char_i == CH_MINUS);
            cnt_o        = cnt_inc1;
            ctrl_o.phase = PH_FIRST;
          end else begin
            take_first = 1'b1;
          end
        end
        PH_FIRST: take_first = 1'b1;
        PH_ZX: begin
          if (dig_ok && dig_val < BASE_HEX) begin
            acc_o        = {{(VALUE_W-BASE_W){1'b0}}, dig_val};
            cnt_o        = cnt_inc2;
            ctrl_o.phase = PH_DIGITS;
          end else begin
            res_valid_o  = 1'b1;
            res_offset_o = cnt_i;
            ctrl_o.phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (ctrl_i.lone_zero && (char_i == CH_LX || char_i == CH_UX)) begin
            ctrl_o.lone_zero = 1'b0;
            ctrl_o.base      = BASE_HEX;
            ctrl_o.phase     = PH_ZX;
          end else begin
            ctrl_o.lone_zero = 1'b0;
            if (dig_ok && dig_val < ctrl_i.base) begin
              acc_o = acc_mac;
              cnt_o = cnt_inc1;
            end else begin
              res_valid_o  = 1'b1;
              res_value_o  = ctrl_i.minus ? (VALUE_W'(0) - acc_i) : acc_i;
              res_offset_o = cnt_i;
              ctrl_o.phase = PH_DONE;
            end
          end
        end
        default: ;
      endcase

      // first character of the number itself
      if (take_first) begin
        if (ctrl_o.base == BASE_AUTO) begin
          if (char_i == CH_ZERO) begin
            ctrl_o.base      = BASE_OCT;
            ctrl_o.lone_zero = 1'b1;
          end else if (dig_ok && dig_val < BASE_DEC) begin
            ctrl_o.base      = BASE_DEC;
            ctrl_o.lone_zero = 1'b0;
          end else begin
            res_valid_o = 1'b1;
          end
        end else if (!(dig_ok && dig_val < ctrl_o.base)) begin
          res_valid_o = 1'b1;
        end else begin
          ctrl_o.lone_zero = (ctrl_o.base == BASE_HEX) && (dig_val == '0);
        end
        if (res_valid_o) begin
          ctrl_o.phase = PH_DONE;
        end else begin
          acc_o        = {{(VALUE_W-BASE_W){1'b0}}, dig_val};
          cnt_o        = cnt_inc1;
          ctrl_o.phase = PH_DIGITS;
        end
      end
    end
  end

endmodule

[design/string_to_integer_parser_core.sv]
// String to integer parser: a character stream in, one parsed value per string out.
// Characters arrive on the s_ side, one word each; s_tuser_i marks the first
// character of a string. Leading blanks and a sign are taken, the radix is the
// configured one or detected (0x hex, leading 0 octal, else decimal), and the
// first character that cannot continue the number yields one word on the m_
// side: the value and the count of characters consumed before it.
// The cfg channel writes the radix (0 for detection, 1 or over 36 a zero result);
// it is sampled when a string starts and is always ready.
// Path: an accepted word waits in the input register, is parsed combinationally,
// and its result is registered in the output register that drives m_.
// Throughput: one character per cycle while the output slot can take a word,
// bounded by the accumulator multiply-add feeding back into itself each cycle.
// If the receiver stalls with a result pending, the input register holds and
// s_tready_o falls; characters that give no result still only move on when
// the output slot can take a word.
// Reset puts the parser in the finished state: characters are ignored until
// one arrives with s_tuser_i set; the radix resets to detection.
// depends on strp_pkg, strp_step and the assertion macro header
`timescale 1ns / 1ps
`include "string_to_integer_parser_core_macros.svh"

module string_to_integer_parser_core import strp_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16,
  localparam int unsigned TDATA_W = ((VALUE_W + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [BASE_W-1:0]  cfg_data_i,     // number_base
  // character stream
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [7:0]         s_tdata_i,      // char_code
  input  logic [0:0]         s_tuser_i,      // first_char
  // result stream
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [TDATA_W-1:0] m_tdata_o       // parsed_value, end_offset, zero fill
);

  logic [BASE_W-1:0]      number_base_q;
  logic                   in_valid_q;
  logic [7:0]             in_char_q;
  logic                   in_first_q;
  logic                   adv;
  strp_ctrl_t             ctrl_q, ctrl_d;
  logic [VALUE_W-1:0]     acc_q, acc_d;
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
  logic                   res_valid;
  logic [VALUE_W-1:0]     res_value;
  logic [OFFSET_BITS-1:0] res_offset;
  logic                   out_valid_q;
  logic [VALUE_W-1:0]     out_value_q;
  logic [OFFSET_BITS-1:0] out_offset_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_AUTO;
    end else if (cfg_valid_i) begin
      number_base_q <= cfg_data_i;
    end
  end

  // parse stage moves when the output slot is free or being emptied
  assign adv        = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_char_q  <= s_tdata_i;
      in_first_q <= s_tuser_i[0];
    end
  end

  // per-character parse logic
  strp_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .ctrl_i        (ctrl_q),
    .acc_i         (acc_q),
    .cnt_i         (cnt_q),
    .number_base_i (number_base_q),
    .char_i        (in_char_q),
    .first_i       (in_first_q),
    .ctrl_o        (ctrl_d),
    .acc_o         (acc_d),
    .cnt_o         (cnt_d),
    .res_valid_o   (res_valid),
    .res_value_o   (res_value),
    .res_offset_o  (res_offset)
  );

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{phase: PH_DONE, minus: 1'b0, lone_zero: 1'b0, base: BASE_AUTO};
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (adv) begin
      ctrl_q <= ctrl_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_value_q  <= res_value;
      out_offset_q <= res_offset;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = TDATA_W'({out_offset_q, out_value_q});

  // a result only enters when the output slot can take it
  `STRP_ASSERT_NOW(a_res_slot_free, adv && res_valid, !out_valid_q || m_tready_i)
  // finished strings stay silent until a new first character
  `STRP_ASSERT_NOW(a_done_silent, in_valid_q && !in_first_q && ctrl_q.phase == PH_DONE,
                   !res_valid)
  // a pending lone zero only lives while collecting digits
  `STRP_ASSERT_NOW(a_lone_zero_phase, ctrl_q.lone_zero, ctrl_q.phase == PH_DIGITS)
  // a stalled result keeps the output valid
  `STRP_ASSERT_NEXT(a_stall_hold, out_valid_q && !m_tready_i, out_valid_q)

endmodule
